// File: rtl/hng_pkg.sv
package hng_pkg;

	localparam int CFG_W        = 11;
	localparam int CFG_IDX_W    = 1;
	localparam int HEIGHT_W     = 8;
	localparam int POS_W        = 10;
	localparam int NXZ_W        = 16;
	localparam int NY_W         = 15;
	localparam int MAP_SIZE_DEF = 1024;
	localparam int MIN_SIZE     = 3;

	// Q1.14 output: the ratio is isqrt((num^2 << 2*FRAC_BITS) / den)
	localparam int FRAC_BITS = 14;
	localparam int ROOT_W    = FRAC_BITS + 1;
	localparam int RAD_W     = 2 * ROOT_W;
	localparam int DIV_STEPS = 2 * FRAC_BITS;
	localparam int STEP_W    = $clog2(DIV_STEPS);
	localparam int SQ_W      = 2 * HEIGHT_W;
	localparam int DEN_W     = SQ_W + 1;

	// Vertical term of the unnormalized normal and its square
	localparam int UP_SCALE = 20;
	localparam int BIAS     = UP_SCALE * UP_SCALE;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_MAP_WIDTH  = 1'b0,
		REG_MAP_HEIGHT = 1'b1
	} cfg_reg_t;

endpackage

// File: rtl/hng_if.sv
interface hng_sample_if;
	import hng_pkg::*;

	logic                valid;
	logic                ready;
	logic [HEIGHT_W-1:0] height;

	modport source (output valid, height, input ready);
	modport sink (input valid, height, output ready);
endinterface

interface hng_normal_if;
	import hng_pkg::*;

	logic                    valid;
	logic                    ready;
	logic [POS_W-1:0]        row;
	logic [POS_W-1:0]        col;
	logic signed [NXZ_W-1:0] normal_x;
	logic [NY_W-1:0]         normal_y;
	logic signed [NXZ_W-1:0] normal_z;

	modport source (output valid, row, col, normal_x, normal_y, normal_z, input ready);
	modport sink (input valid, row, col, normal_x, normal_y, normal_z, output ready);
endinterface

interface hng_cfg_if;
	import hng_pkg::*;

	logic                 valid;
	logic                 ready;
	logic [CFG_IDX_W-1:0] index;
	logic [CFG_W-1:0]     data;

	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

// File: rtl/hng_ram.sv
module hng_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

// File: rtl/hng_ratio.sv
module hng_ratio (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         start,
	input  logic [hng_pkg::SQ_W-1:0]     num2,
	input  logic [hng_pkg::DEN_W-1:0]    den,
	output logic                         done,
	output logic [hng_pkg::ROOT_W-1:0]   root
);
	import hng_pkg::*;

	localparam int SREM_W = ROOT_W + 2;
	localparam int SACC_W = ROOT_W + 4;

	typedef enum logic [3:0] {
		R_IDLE = 4'b0001,
		R_INIT = 4'b0010,
		R_DIV  = 4'b0100,
		R_SQRT = 4'b1000
	} rstate_t;

	rstate_t           state_q;
	logic [STEP_W-1:0] step_q;
	logic              done_q;
	logic [SQ_W-1:0]   num2_q;
	logic [DEN_W-1:0]  den_q;
	logic [DEN_W-1:0]  rem_q;
	logic [RAD_W-1:0]  rad_q;
	logic [SREM_W-1:0] srem_q;
	logic [ROOT_W-1:0] root_q;

	logic [DEN_W-1:0]  num_ext;
	logic              q0;
	logic [DEN_W:0]    rem2;
	logic              dbit;
	logic [DEN_W-1:0]  rem_nx;
	logic [SACC_W-1:0] sacc;
	logic [SACC_W-1:0] trial;
	logic              sbit;
	logic [SREM_W-1:0] srem_nx;

	// Divide: one quotient bit a cycle, restoring
	always_comb begin
		num_ext = {1'b0, num2_q};
		q0      = num_ext >= den_q;
		rem2    = {rem_q, 1'b0};
		dbit    = rem2 >= {1'b0, den_q};
		rem_nx  = dbit ? DEN_W'(rem2 - {1'b0, den_q}) : DEN_W'(rem2);
	end

	// Square root: two radicand bits in, one root bit out a cycle
	always_comb begin
		sacc    = {srem_q, rad_q[RAD_W-1 -: 2]};
		trial   = {2'b00, root_q, 2'b01};
		sbit    = sacc >= trial;
		srem_nx = sbit ? SREM_W'(sacc - trial) : SREM_W'(sacc);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= R_IDLE;
			step_q  <= '0;
			done_q  <= 1'b0;
		end else begin
			done_q <= 1'b0;
			unique case (state_q)
				R_IDLE: begin
					if (start) begin
						state_q <= R_INIT;
					end
				end
				R_INIT: begin
					step_q  <= STEP_W'(DIV_STEPS - 1);
					state_q <= R_DIV;
				end
				R_DIV: begin
					if (step_q == '0) begin
						step_q  <= STEP_W'(ROOT_W - 1);
						state_q <= R_SQRT;
					end else begin
						step_q <= step_q - STEP_W'(1);
					end
				end
				R_SQRT: begin
					if (step_q == '0) begin
						done_q  <= 1'b1;
						state_q <= R_IDLE;
					end else begin
						step_q <= step_q - STEP_W'(1);
					end
				end
				default: state_q <= R_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			R_IDLE: begin
				if (start) begin
					num2_q <= num2;
					den_q  <= den;
				end
			end
			R_INIT: begin
				rem_q <= q0 ? DEN_W'(num_ext - den_q) : num_ext;
				rad_q <= RAD_W'(q0);
			end
			R_DIV: begin
				rem_q <= rem_nx;
				rad_q <= {rad_q[RAD_W-2:0], dbit};
				if (step_q == '0) begin
					srem_q <= '0;
					root_q <= '0;
				end
			end
			R_SQRT: begin
				srem_q <= srem_nx;
				root_q <= {root_q[ROOT_W-2:0], sbit};
				rad_q  <= {rad_q[RAD_W-3:0], 2'b00};
			end
			default: begin
			end
		endcase
	end

	assign done = done_q;
	assign root = root_q;

`ifndef SYNTHESIS
	a_root_range: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |-> root_q <= ROOT_W'(2 ** FRAC_BITS))
		else $error("ratio above one");
	a_start_idle: assert property (@(posedge clk) disable iff (!arst_n)
		start |-> state_q == R_IDLE)
		else $error("start while busy");
	a_div_to_sqrt: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == R_DIV && step_q == '0) |=> state_q == R_SQRT)
		else $error("divide did not hand over to square root");
`endif

endmodule

// File: rtl/heightmap_normal_generator.sv
// Channel  Dir  Payload                                   Accepted when
// sample   in   height                                    sample.valid && sample.ready
// normal   out  row, col, normal_x, normal_y, normal_z    normal.valid && normal.ready
// cfg      in   index (0 map_width, 1 map_height), data   cfg.valid && cfg.ready
//
// After an interior sample, the next one is taken only once the buffer read, squaring,
// summing and the three bit-serial ratio units (28 divide steps, then 15 square-root
// steps) are through and the result is loaded; after a border sample, once the buffer read is done.
// Reset clears counters, window and control; line buffers are not cleared.
// A waiting result does not block the next sample; only a second finished
// result waits for the output register to empty.
module heightmap_normal_generator #(
	parameter int MAP_SIZE = hng_pkg::MAP_SIZE_DEF
) (
	input logic         clk,
	input logic         arst_n,
	hng_sample_if.sink  sample,
	hng_normal_if.source normal,
	hng_cfg_if.sink     cfg
);
	import hng_pkg::*;

	localparam int CW = $clog2(MAP_SIZE);
	localparam int SW = (CW + 1 > CFG_W) ? CW + 1 : CFG_W;

	typedef enum logic [5:0] {
		ST_IDLE = 6'b000001,
		ST_READ = 6'b000010,
		ST_SQ   = 6'b000100,
		ST_SUM  = 6'b001000,
		ST_RUN  = 6'b010000,
		ST_DONE = 6'b100000
	} state_t;

	state_t              state_q;
	logic [CFG_W-1:0]    width_q;
	logic [CFG_W-1:0]    height_q;
	logic [CW-1:0]       col_q;
	logic [CW-1:0]       row_q;
	logic                inner_q;
	logic                out_valid_q;
	logic [HEIGHT_W-1:0] top1_q;
	logic [HEIGHT_W-1:0] mid1_q;
	logic [HEIGHT_W-1:0] mid2_q;
	logic [HEIGHT_W-1:0] bot1_q;

	logic [HEIGHT_W-1:0] cur_q;
	logic [POS_W-1:0]    rm1_q;
	logic [POS_W-1:0]    cm1_q;
	logic [HEIGHT_W-1:0] mag_a_q;
	logic [HEIGHT_W-1:0] mag_b_q;
	logic                neg_a_q;
	logic                neg_b_q;
	logic [SQ_W-1:0]     sq_a_q;
	logic [SQ_W-1:0]     sq_b_q;
	logic [POS_W-1:0]    orow_q;
	logic [POS_W-1:0]    ocol_q;
	logic [NXZ_W-1:0]    onx_q;
	logic [NY_W-1:0]     ony_q;
	logic [NXZ_W-1:0]    onz_q;

	logic                accept;
	logic                cfg_wr;
	logic                load;
	logic [SW-1:0]       w_raw;
	logic [SW-1:0]       h_raw;
	logic [SW-1:0]       w_use;
	logic [SW-1:0]       h_use;
	logic [SW-1:0]       col_nx;
	logic [SW-1:0]       row_nx;
	logic [HEIGHT_W-1:0] top_rd;
	logic [HEIGHT_W-1:0] mid_rd;
	logic signed [HEIGHT_W:0] da;
	logic signed [HEIGHT_W:0] db;
	logic [DEN_W-1:0]    den;
	logic                start;
	logic                done_x;
	logic                done_y;
	logic                done_z;
	logic [ROOT_W-1:0]   root_x;
	logic [ROOT_W-1:0]   root_y;
	logic [ROOT_W-1:0]   root_z;
	logic [NXZ_W-1:0]    ext_x;
	logic [NXZ_W-1:0]    ext_z;

	assign accept       = sample.valid && sample.ready;
	assign cfg_wr       = cfg.valid && cfg.ready;
	assign sample.ready = state_q == ST_IDLE;
	assign cfg.ready    = 1'b1;
	assign load         = state_q == ST_DONE && (!out_valid_q || normal.ready);
	assign start        = state_q == ST_SUM;

	// Saturate the used map size to 3 .. MAP_SIZE
	always_comb begin
		w_raw  = SW'(width_q);
		h_raw  = SW'(height_q);
		w_use  = (w_raw < SW'(MIN_SIZE)) ? SW'(MIN_SIZE) :
			(w_raw > SW'(MAP_SIZE)) ? SW'(MAP_SIZE) : w_raw;
		h_use  = (h_raw < SW'(MIN_SIZE)) ? SW'(MIN_SIZE) :
			(h_raw > SW'(MAP_SIZE)) ? SW'(MAP_SIZE) : h_raw;
		col_nx = SW'(col_q) + SW'(1);
		row_nx = SW'(row_q) + SW'(1);
	end

	// Above minus below, left minus right around the pixel one row and column back
	always_comb begin
		da  = $signed({1'b0, top1_q}) - $signed({1'b0, bot1_q});
		db  = $signed({1'b0, mid2_q}) - $signed({1'b0, mid_rd});
		den = DEN_W'(sq_a_q) + DEN_W'(sq_b_q) + DEN_W'(BIAS);
	end

	hng_ram #(.WIDTH(HEIGHT_W), .DEPTH(MAP_SIZE)) u_line_two (
		.clk   (clk),
		.we    (state_q == ST_READ),
		.waddr (col_q),
		.wdata (mid_rd),
		.re    (accept),
		.raddr (col_q),
		.rdata (top_rd)
	);

	hng_ram #(.WIDTH(HEIGHT_W), .DEPTH(MAP_SIZE)) u_line_one (
		.clk   (clk),
		.we    (state_q == ST_READ),
		.waddr (col_q),
		.wdata (cur_q),
		.re    (accept),
		.raddr (col_q),
		.rdata (mid_rd)
	);

	hng_ratio u_ratio_x (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.num2   (sq_a_q),
		.den    (den),
		.done   (done_x),
		.root   (root_x)
	);

	hng_ratio u_ratio_y (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.num2   (SQ_W'(BIAS)),
		.den    (den),
		.done   (done_y),
		.root   (root_y)
	);

	hng_ratio u_ratio_z (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.num2   (sq_b_q),
		.den    (den),
		.done   (done_z),
		.root   (root_z)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			width_q     <= CFG_W'(MAP_SIZE_DEF);
			height_q    <= CFG_W'(MAP_SIZE_DEF);
			col_q       <= '0;
			row_q       <= '0;
			inner_q     <= 1'b0;
			out_valid_q <= 1'b0;
			top1_q      <= '0;
			mid1_q      <= '0;
			mid2_q      <= '0;
			bot1_q      <= '0;
		end else begin
			if (load) begin
				out_valid_q <= 1'b1;
			end else if (normal.ready) begin
				out_valid_q <= 1'b0;
			end

			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						inner_q <= row_q >= CW'(2) && col_q >= CW'(2);
						state_q <= ST_READ;
					end
				end
				ST_READ: begin
					top1_q <= top_rd;
					mid2_q <= mid1_q;
					mid1_q <= mid_rd;
					bot1_q <= cur_q;
					if (col_nx >= w_use) begin
						col_q <= '0;
						row_q <= (row_nx >= h_use) ? '0 : CW'(row_nx);
					end else begin
						col_q <= CW'(col_nx);
					end
					state_q <= inner_q ? ST_SQ : ST_IDLE;
				end
				ST_SQ:  state_q <= ST_SUM;
				ST_SUM: state_q <= ST_RUN;
				ST_RUN: begin
					if (done_x && done_y && done_z) begin
						state_q <= ST_DONE;
					end
				end
				ST_DONE: begin
					if (load) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase

			// a register write restarts the frame
			if (cfg_wr) begin
				unique case (cfg_reg_t'(cfg.index))
					REG_MAP_WIDTH:  width_q  <= cfg.data;
					REG_MAP_HEIGHT: height_q <= cfg.data;
				endcase
				col_q <= '0;
				row_q <= '0;
			end
		end
	end

	always_comb begin
		ext_x = {1'b0, root_x};
		ext_z = {1'b0, root_z};
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			cur_q <= sample.height;
			rm1_q <= POS_W'(row_q - CW'(1));
			cm1_q <= POS_W'(col_q - CW'(1));
		end
		if (state_q == ST_READ) begin
			neg_a_q <= da[HEIGHT_W];
			neg_b_q <= db[HEIGHT_W];
			mag_a_q <= da[HEIGHT_W] ? HEIGHT_W'(-da) : da[HEIGHT_W-1:0];
			mag_b_q <= db[HEIGHT_W] ? HEIGHT_W'(-db) : db[HEIGHT_W-1:0];
		end
		if (state_q == ST_SQ) begin
			sq_a_q <= mag_a_q * mag_a_q;
			sq_b_q <= mag_b_q * mag_b_q;
		end
		if (load) begin
			orow_q <= rm1_q;
			ocol_q <= cm1_q;
			onx_q  <= neg_a_q ? NXZ_W'(-ext_x) : ext_x;
			ony_q  <= NY_W'(root_y);
			onz_q  <= neg_b_q ? NXZ_W'(-ext_z) : ext_z;
		end
	end

	assign normal.valid    = out_valid_q;
	assign normal.row      = orow_q;
	assign normal.col      = ocol_q;
	assign normal.normal_x = onx_q;
	assign normal.normal_y = ony_q;
	assign normal.normal_z = onz_q;

`ifndef SYNTHESIS
	a_lanes_lockstep: assert property (@(posedge clk) disable iff (!arst_n)
		done_x == done_y && done_y == done_z)
		else $error("ratio lanes out of step");
	a_accept_reads: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> state_q == ST_READ)
		else $error("accepted word not followed by buffer read");
	a_up_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> ony_q != '0)
		else $error("up component of a normal is zero");
	a_pos_in_map: assert property (@(posedge clk) disable iff (!arst_n)
		SW'(col_q) < w_use && SW'(row_q) < h_use)
		else $error("position counter beyond map size");
`endif

endmodule

// File: tb/hng_normal_checker.sv
module hng_normal_checker
	import hng_pkg::*;
(
	input  logic  clk,
	input  logic  arst_n,
	hng_sample_if smp,
	hng_normal_if nrm,
	hng_cfg_if    cfg,
	output int    errors,
	output int    outstanding
);
	timeunit 1ns;
	timeprecision 1ps;

	typedef struct packed {
		logic [POS_W-1:0]        row;
		logic [POS_W-1:0]        col;
		logic signed [NXZ_W-1:0] normal_x;
		logic [NY_W-1:0]         normal_y;
		logic signed [NXZ_W-1:0] normal_z;
	} normal_word_t;

	// rows r-2 and r-1 of the current frame
	logic [HEIGHT_W-1:0] row_minus2 [MAP_SIZE_DEF];
	logic [HEIGHT_W-1:0] row_minus1 [MAP_SIZE_DEF];
	// 3x3 neighborhood taps that feed the differences
	logic [HEIGHT_W-1:0] up_prev, mid_prev, mid_prev2, cur_prev;
	logic [CFG_W-1:0]    map_w, map_h;
	int unsigned         row_pos, col_pos;
	int                  fails;
	normal_word_t        expected_normals [$];

	function automatic int unsigned used_size(logic [CFG_W-1:0] v);
		if (v < MIN_SIZE)
			return MIN_SIZE;
		if (v > MAP_SIZE_DEF)
			return MAP_SIZE_DEF;
		return v;
	endfunction

	// trunc(2^FRAC_BITS * num / sqrt(sum)), bit-by-bit integer root
	function automatic logic [NY_W:0] q14_ratio(int unsigned num, int unsigned sum);
		longint unsigned quot;
		longint unsigned trial;
		logic [NY_W:0]   root;
		quot = ((longint'(num) * num) << (2 * FRAC_BITS)) / sum;
		root = '0;
		for (int b = NY_W; b >= 0; b--) begin
			trial = root | (longint'(1) << b);
			if (trial * trial <= quot)
				root = trial[NY_W:0];
		end
		return root;
	endfunction

	task automatic note_failure(input string what, input normal_word_t want,
			input normal_word_t got);
		fails++;
		if (fails <= 10)
			$display("[%0t] %s: expected row %0d col %0d n (%0d %0d %0d), got row %0d col %0d n (%0d %0d %0d)",
				$realtime, what, want.row, want.col, want.normal_x, want.normal_y, want.normal_z,
				got.row, got.col, got.normal_x, got.normal_y, got.normal_z);
	endtask

	task automatic absorb_height(input logic [HEIGHT_W-1:0] h);
		int unsigned         w, ht, c, r, sum, mag_a, mag_b;
		int                  a, b;
		logic [HEIGHT_W-1:0] up, mid;
		logic [NY_W:0]       mag;
		normal_word_t        nw;
		w = used_size(map_w);
		ht = used_size(map_h);
		c = (col_pos >= MAP_SIZE_DEF) ? 0 : col_pos;
		r = row_pos;
		up = row_minus2[c];
		mid = row_minus1[c];
		row_minus2[c] = mid;
		row_minus1[c] = h;
		if (r >= 2 && c >= 2) begin
			a = int'(up_prev) - int'(cur_prev);
			b = int'(mid_prev2) - int'(mid);
			mag_a = (a < 0) ? -a : a;
			mag_b = (b < 0) ? -b : b;
			sum = mag_a * mag_a + mag_b * mag_b + BIAS;
			nw.row = POS_W'(r - 1);
			nw.col = POS_W'(c - 1);
			mag = q14_ratio(mag_a, sum);
			nw.normal_x = (a < 0) ? NXZ_W'(-int'(mag)) : NXZ_W'(mag);
			nw.normal_y = NY_W'(q14_ratio(UP_SCALE, sum));
			mag = q14_ratio(mag_b, sum);
			nw.normal_z = (b < 0) ? NXZ_W'(-int'(mag)) : NXZ_W'(mag);
			expected_normals.push_back(nw);
		end
		up_prev = up;
		mid_prev2 = mid_prev;
		mid_prev = mid;
		cur_prev = h;
		c++;
		if (c >= w) begin
			c = 0;
			r++;
			if (r >= ht)
				r = 0;
		end
		col_pos = c;
		row_pos = r;
	endtask

	always @(posedge clk or negedge arst_n) begin
		normal_word_t got, want;
		if (!arst_n) begin
			up_prev = '0;
			mid_prev = '0;
			mid_prev2 = '0;
			cur_prev = '0;
			map_w = CFG_W'(MAP_SIZE_DEF);
			map_h = CFG_W'(MAP_SIZE_DEF);
			row_pos = 0;
			col_pos = 0;
			fails = 0;
			expected_normals.delete();
			errors <= 0;
			outstanding <= 0;
		end else begin
			// compare before adding: a word never leaves in the cycle its sample enters
			if (nrm.valid && nrm.ready) begin
				got.row = nrm.row;
				got.col = nrm.col;
				got.normal_x = nrm.normal_x;
				got.normal_y = nrm.normal_y;
				got.normal_z = nrm.normal_z;
				if (expected_normals.size() == 0) begin
					note_failure("unexpected normal", '0, got);
				end else begin
					want = expected_normals.pop_front();
					if (got.row !== want.row || got.col !== want.col ||
							got.normal_x !== want.normal_x ||
							got.normal_y !== want.normal_y ||
							got.normal_z !== want.normal_z)
						note_failure("normal mismatch", want, got);
				end
			end
			if (cfg.valid && cfg.ready) begin
				if (cfg.index == REG_MAP_WIDTH)
					map_w = cfg.data;
				else
					map_h = cfg.data;
				row_pos = 0;
				col_pos = 0;
			end
			if (smp.valid && smp.ready)
				absorb_height(smp.height);
			errors <= fails;
			outstanding <= expected_normals.size();
		end
	end

endmodule

// File: tb/tb_heightmap_normal_generator.sv
module tb_heightmap_normal_generator;
	import hng_pkg::*;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int RANDOM_ITEMS = 500;
	localparam int WIDE_ROW     = 300;
	localparam int HOLD_OFF     = 60;
	localparam int IDLE_LIMIT   = 2000;

	// 3x3 frames: steep slope each way, then a pattern with zero slope at the centre
	localparam logic [HEIGHT_W-1:0] CORNER_FRAMES [27] = '{
		8'd0,   8'd255, 8'd0,   8'd0,   8'd128, 8'd255, 8'd255, 8'd0,   8'd255,
		8'd255, 8'd0,   8'd255, 8'd255, 8'd127, 8'd0,   8'd0,   8'd255, 8'd0,
		8'd170, 8'd85,  8'd170, 8'd85,  8'd85,  8'd85,  8'd170, 8'd85,  8'd170
	};

	logic clk = 1'b0;
	logic arst_n;
	bit   tx_calm = 1'b0;
	bit   rx_calm = 1'b0;
	int   mismatch_count;
	int   pending_normals;
	int   idle_cycles = 0;

	hng_sample_if smp_ch ();
	hng_normal_if nrm_ch ();
	hng_cfg_if    cfg_ch ();

	heightmap_normal_generator u_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.sample (smp_ch),
		.normal (nrm_ch),
		.cfg    (cfg_ch)
	);

	hng_normal_checker u_check (
		.clk         (clk),
		.arst_n      (arst_n),
		.smp         (smp_ch),
		.nrm         (nrm_ch),
		.cfg         (cfg_ch),
		.errors      (mismatch_count),
		.outstanding (pending_normals)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	always @(posedge clk) begin
		if (!arst_n || (smp_ch.valid && smp_ch.ready) || (nrm_ch.valid && nrm_ch.ready) ||
				(cfg_ch.valid && cfg_ch.ready)) begin
			idle_cycles <= 0;
		end else if (idle_cycles >= IDLE_LIMIT) begin
			$display("simulation failed");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

	// normal channel receiver: random stall before every word unless rx_calm is set
	initial begin
		int unsigned stall;
		nrm_ch.ready = 1'b0;
		forever begin
			stall = rx_calm ? 0 : $urandom_range(0, 10);
			if (stall != 0) begin
				nrm_ch.ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			nrm_ch.ready <= 1'b1;
			do @(posedge clk); while (!nrm_ch.valid);
		end
	end

	task automatic send_height(input logic [HEIGHT_W-1:0] h);
		int unsigned gap;
		gap = tx_calm ? 0 : $urandom_range(0, 10);
		if (gap != 0) begin
			smp_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		smp_ch.valid <= 1'b1;
		smp_ch.height <= h;
		do @(posedge clk); while (!smp_ch.ready);
	endtask

	task automatic wait_for_normals();
		smp_ch.valid <= 1'b0;
		do @(posedge clk); while (pending_normals != 0);
	endtask

	// drain, then hold off while a border sample may still be in flight
	task automatic settle();
		wait_for_normals();
		repeat (HOLD_OFF) @(posedge clk);
	endtask

	// drop valid after each write so the next write starts on a later edge
	task automatic write_reg(input cfg_reg_t idx, input logic [CFG_W-1:0] value);
		cfg_ch.valid <= 1'b1;
		cfg_ch.index <= idx;
		cfg_ch.data <= value;
		do @(posedge clk); while (!cfg_ch.ready);
		cfg_ch.valid <= 1'b0;
		@(posedge clk);
	endtask

	initial begin
		int unsigned cur_w, cur_h, n, sel, style, base, random_sent;
		int          level;
		logic [CFG_W-1:0] w_val, h_val;
		smp_ch.valid = 1'b0;
		smp_ch.height = '0;
		cfg_ch.valid = 1'b0;
		cfg_ch.index = REG_MAP_WIDTH;
		cfg_ch.data = '0;
		arst_n = 1'b0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// both sizes below the minimum, clamp to 3x3
		write_reg(REG_MAP_WIDTH, 11'd0);
		write_reg(REG_MAP_HEIGHT, 11'd2);
		foreach (CORNER_FRAMES[i])
			send_height(CORNER_FRAMES[i]);
		settle();

		// wide rows; height above the limit saturates
		write_reg(REG_MAP_WIDTH, CFG_W'(WIDE_ROW));
		write_reg(REG_MAP_HEIGHT, 11'd2047);
		for (int i = 0; i < 2 * WIDE_ROW + 40; i++)
			send_height(HEIGHT_W'($urandom_range(0, 255)));
		settle();

		// tallest map, narrow rows
		write_reg(REG_MAP_WIDTH, 11'd1);
		write_reg(REG_MAP_HEIGHT, 11'd1024);
		for (int i = 0; i < 3 * 40; i++)
			send_height(HEIGHT_W'($urandom_range(0, 255)));
		settle();

		cur_w = 3;
		cur_h = MAP_SIZE_DEF;
		random_sent = 0;
		level = 128;
		while (random_sent < RANDOM_ITEMS) begin
			sel = $urandom_range(0, 3);
			w_val = ($urandom_range(0, 7) == 0) ? CFG_W'($urandom_range(0, 2)) :
				CFG_W'($urandom_range(3, 12));
			h_val = ($urandom_range(0, 7) == 0) ? CFG_W'($urandom_range(0, 2)) :
				CFG_W'($urandom_range(3, 8));
			if (sel != 1) begin
				write_reg(REG_MAP_WIDTH, w_val);
				cur_w = (w_val < MIN_SIZE) ? MIN_SIZE : w_val;
			end
			if (sel != 0 || cur_h > 16) begin
				write_reg(REG_MAP_HEIGHT, h_val);
				cur_h = (h_val < MIN_SIZE) ? MIN_SIZE : h_val;
			end
			n = cur_w * cur_h * $urandom_range(1, 3) + $urandom_range(0, 2 * cur_w);
			style = $urandom_range(0, 3);
			base = $urandom_range(0, 240);
			tx_calm = ($urandom_range(0, 3) == 0);
			rx_calm = ($urandom_range(0, 3) == 0);
			for (int i = 0; i < n; i++) begin
				case (style)
					0: level = $urandom_range(0, 255);
					1: begin
						// smooth terrain: small random walk
						level = level + int'($urandom_range(0, 8)) - 4;
						level = (level < 0) ? 0 : (level > 255) ? 255 : level;
					end
					2: level = $urandom_range(0, 1) ? 255 : 0;
					default: level = base + $urandom_range(0, 15);
				endcase
				send_height(HEIGHT_W'(level));
				if ($urandom_range(0, 39) == 0)
					wait_for_normals();
			end
			random_sent += n;
			settle();
		end

		if (mismatch_count == 0 && pending_normals == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

endmodule

// File: heightmap_normal_generator.f
rtl/hng_pkg.sv
rtl/hng_if.sv
rtl/hng_ram.sv
rtl/hng_ratio.sv
rtl/heightmap_normal_generator.sv
tb/hng_normal_checker.sv
tb/tb_heightmap_normal_generator.sv
